### hw/rtl/pcb_pkg.sv
package pcb_pkg;

    // default sizes of the grid store
    localparam int DEF_MAX_COLUMNS = 512;
    localparam int DEF_MAX_ROWS    = 256;
    localparam int DEF_SLOTS       = 4;
    localparam int DEF_INDEX_BITS  = 16;

    // fixed field widths
    localparam int SIZE_W   = 7;   // cell width or height
    localparam int DIM_W    = 13;  // effective grid size, up to 4096
    localparam int CELL_W   = 12;  // cell coordinate, up to 4095
    localparam int NUM_W    = 12;  // dividend of the cell divide
    localparam int EDGE_W   = 24;  // grid size * cell size in Q20.4
    localparam int DIV_STEP = 4;   // quotient bits per cycle
    localparam int DIV_ITER = NUM_W / DIV_STEP;
    localparam int DCNT_W   = $clog2(DIV_ITER);

    // commands
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_BIN   = 2'd1;
    localparam logic [1:0] CMD_MOVE  = 2'd2;

    // result status
    localparam logic [2:0] ST_CLEARED   = 3'd0;
    localparam logic [2:0] ST_PLACED    = 3'd1;
    localparam logic [2:0] ST_OVERWRITE = 3'd2;
    localparam logic [2:0] ST_OUTSIDE   = 3'd3;
    localparam logic [2:0] ST_SAME      = 3'd4;

    // register indexes
    localparam logic [2:0] REG_CELL_WIDTH   = 3'd0;
    localparam logic [2:0] REG_CELL_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_GRID_COLUMNS = 3'd2;
    localparam logic [2:0] REG_GRID_ROWS    = 3'd3;
    localparam logic [2:0] REG_TIME_STEP    = 3'd4;

    // operation kinds handed from front to back
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PLACE = 2'd1;
    localparam logic [1:0] OP_PEEK  = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
        logic [DIM_W-1:0]  dim_x;
        logic [DIM_W-1:0]  dim_y;
        logic [15:0]       time_step;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic              s_in;
        logic              e_in;
        logic [CELL_W-1:0] s_col;
        logic [CELL_W-1:0] s_row;
        logic [CELL_W-1:0] e_col;
        logic [CELL_W-1:0] e_row;
        logic [15:0]       part;
    } op_t;

    typedef struct packed {
        logic [8:0] cell_column;
        logic [7:0] cell_row;
        logic [2:0] status;
        logic       removed;
        logic [2:0] count_after;
    } result_t;

endpackage

### hw/rtl/pcb_ram.sv
module pcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/pcb_fifo.sv
module pcb_fifo #(
    parameter type item_t = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  item_t din,
    input  logic  pop,
    output logic  empty,
    output item_t dout
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // two-entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

### hw/rtl/pcb_div.sv
module pcb_div import pcb_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [SIZE_W-1:0] den,
    output logic              busy,
    output logic [NUM_W-1:0]  quo
);

    logic              busy_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [NUM_W-1:0]  nq_reg;
    logic [SIZE_W-1:0] den_reg;
    logic [SIZE_W-1:0] rem_next;
    logic [NUM_W-1:0]  nq_next;
    logic [SIZE_W:0]   trial;

    assign busy = busy_reg;
    assign quo  = nq_reg;

    // restoring division, a few quotient bits per cycle
    always_comb
    begin
        rem_next = rem_reg;
        nq_next  = nq_reg;
        trial    = '0;
        for (int k = 0; k < DIV_STEP; k++)
        begin
            trial   = {rem_next, nq_next[NUM_W-1]};
            nq_next = {nq_next[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                trial      = trial - {1'b0, den_reg};
                nq_next[0] = 1'b1;
            end
            rem_next = trial[SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DCNT_W'(DIV_ITER - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            nq_reg  <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
        end
    end

endmodule

### hw/rtl/pcb_front.sv
module pcb_front import pcb_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        hold,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  cmd,
    input  logic [15:0] particle_index,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [15:0] vel_x,
    input  logic [15:0] vel_y,
    input  logic [15:0] end_x,
    input  logic [15:0] end_y,
    input  logic        op_full,
    output logic        op_push,
    output op_t         op
);

    localparam logic [2:0] F_IDLE   = 3'd0;
    localparam logic [2:0] F_MUL    = 3'd1;
    localparam logic [2:0] F_SUM    = 3'd2;
    localparam logic [2:0] F_MSTART = 3'd3;
    localparam logic [2:0] F_DIVA   = 3'd4;
    localparam logic [2:0] F_DIVB   = 3'd5;
    localparam logic [2:0] F_PUSH   = 3'd6;

    logic [2:0]  state_reg, state_next;
    op_t         op_reg, op_next;
    logic [1:0]  cmd_reg;
    logic [15:0] px_reg, py_reg, vx_reg, vy_reg, ex_reg, ey_reg;
    logic signed [32:0] prod_x_reg, prod_y_reg;
    logic signed [32:0] prod_x_next, prod_y_next;
    logic        neg_x_reg, neg_y_reg, neg_x_next, neg_y_next;
    logic [EDGE_W-1:0] edge_x_reg, edge_y_reg;
    logic [19:0] area_x, area_y;
    logic        accept;
    logic        div_start;
    logic [NUM_W-1:0] num_x, num_y, quo_x, quo_y;
    logic        busy_x, busy_y;
    logic [33:0] sum_x, sum_y, mag_x, mag_y;
    logic signed [15:0] mul_a_x, mul_a_y;
    logic signed [16:0] mul_b;
    logic        in_x, in_y;
    logic [CELL_W-1:0] cell_x, cell_y;

    assign full    = (state_reg != F_IDLE) || hold;
    assign accept  = push && !full;
    assign op      = op_reg;

    // bin axis: truncated quotient, small negatives fall in cell zero
    function automatic logic bin_in(input logic neg, input logic [NUM_W-1:0] q,
                                    input logic [DIM_W-1:0] dim);
        bin_in = !(neg && (q != '0)) && ({1'b0, q} < dim);
    endfunction

    // move axis: inclusive far edge
    function automatic logic move_in(input logic [15:0] v, input logic [DIM_W-1:0] dim,
                                     input logic [EDGE_W-1:0] lim);
        move_in = (dim != '0) && !v[15] && ({9'd0, v[14:0]} <= lim);
    endfunction

    function automatic logic [CELL_W-1:0] move_cell(input logic [NUM_W-1:0] q,
                                                    input logic [DIM_W-1:0] dim);
        logic [DIM_W-1:0] last;
        last = dim - 1'b1;
        move_cell = ({1'b0, q} >= dim) ? last[CELL_W-1:0] : q;
    endfunction

    // per-axis cell dividers
    pcb_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_x),
        .den   (cfg.size_x),
        .busy  (busy_x),
        .quo   (quo_x)
    );

    pcb_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_y),
        .den   (cfg.size_y),
        .busy  (busy_y),
        .quo   (quo_y)
    );

    // prediction products and world edges
    assign mul_a_x = vx_reg;
    assign mul_a_y = vy_reg;
    assign mul_b   = {1'b0, cfg.time_step};
    assign prod_x_next = mul_a_x * mul_b;
    assign prod_y_next = mul_a_y * mul_b;
    assign area_x  = cfg.dim_x * cfg.size_x;
    assign area_y  = cfg.dim_y * cfg.size_y;

    // exact predicted position, scale 2^-20
    assign sum_x = {{2{px_reg[15]}}, px_reg, 16'd0} + {prod_x_reg[32], prod_x_reg};
    assign sum_y = {{2{py_reg[15]}}, py_reg, 16'd0} + {prod_y_reg[32], prod_y_reg};
    assign mag_x = sum_x[33] ? (34'd0 - sum_x) : sum_x;
    assign mag_y = sum_y[33] ? (34'd0 - sum_y) : sum_y;

    // classification of the finished quotients
    always_comb
    begin
        if (cmd_reg == CMD_BIN)
        begin
            in_x   = bin_in(neg_x_reg, quo_x, cfg.dim_x);
            in_y   = bin_in(neg_y_reg, quo_y, cfg.dim_y);
            cell_x = quo_x;
            cell_y = quo_y;
        end
        else if (state_reg == F_DIVA)
        begin
            in_x   = move_in(px_reg, cfg.dim_x, edge_x_reg);
            in_y   = move_in(py_reg, cfg.dim_y, edge_y_reg);
            cell_x = move_cell(quo_x, cfg.dim_x);
            cell_y = move_cell(quo_y, cfg.dim_y);
        end
        else
        begin
            in_x   = move_in(ex_reg, cfg.dim_x, edge_x_reg);
            in_y   = move_in(ey_reg, cfg.dim_y, edge_y_reg);
            cell_x = move_cell(quo_x, cfg.dim_x);
            cell_y = move_cell(quo_y, cfg.dim_y);
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        neg_x_next = neg_x_reg;
        neg_y_next = neg_y_reg;
        div_start  = 1'b0;
        num_x      = mag_x[31:20];
        num_y      = mag_y[31:20];
        op_push    = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    op_next      = '0;
                    op_next.part = particle_index;
                    unique case (cmd)
                        CMD_CLEAR: state_next = F_PUSH;
                        CMD_BIN:   state_next = F_MUL;
                        CMD_MOVE:  state_next = F_MSTART;
                        default:   state_next = F_IDLE;
                    endcase
                end
            end
            F_MUL:
            begin
                state_next = F_SUM;
            end
            F_SUM:
            begin
                div_start  = 1'b1;
                neg_x_next = sum_x[33];
                neg_y_next = sum_y[33];
                state_next = F_DIVA;
            end
            F_MSTART:
            begin
                div_start  = 1'b1;
                num_x      = {1'b0, px_reg[14:4]};
                num_y      = {1'b0, py_reg[14:4]};
                state_next = F_DIVA;
            end
            F_DIVA:
            begin
                if (!busy_x && !busy_y)
                begin
                    if (cmd_reg == CMD_BIN)
                    begin
                        op_next.kind  = OP_PLACE;
                        op_next.e_in  = in_x && in_y;
                        op_next.e_col = cell_x;
                        op_next.e_row = cell_y;
                        state_next    = F_PUSH;
                    end
                    else
                    begin
                        op_next.s_in  = in_x && in_y;
                        op_next.s_col = cell_x;
                        op_next.s_row = cell_y;
                        div_start     = 1'b1;
                        num_x         = {1'b0, ex_reg[14:4]};
                        num_y         = {1'b0, ey_reg[14:4]};
                        state_next    = F_DIVB;
                    end
                end
            end
            F_DIVB:
            begin
                if (!busy_x && !busy_y)
                begin
                    op_next.e_in  = in_x && in_y;
                    op_next.e_col = cell_x;
                    op_next.e_row = cell_y;
                    if ((op_reg.s_in == (in_x && in_y)) &&
                        (!op_reg.s_in || (op_reg.s_col == cell_x && op_reg.s_row == cell_y)))
                    begin
                        op_next.kind = OP_PEEK;
                    end
                    else
                    begin
                        op_next.kind = OP_PLACE;
                    end
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!op_full)
                begin
                    op_push    = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // item payload and datapath registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        edge_x_reg <= {area_x, 4'd0};
        edge_y_reg <= {area_y, 4'd0};
        if (state_reg == F_MUL)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
        if (accept)
        begin
            cmd_reg  <= cmd;
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            vx_reg   <= vel_x;
            vy_reg   <= vel_y;
            ex_reg   <= end_x;
            ey_reg   <= end_y;
        end
    end

endmodule

### hw/rtl/pcb_back.sv
module pcb_back import pcb_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int SLOTS       = DEF_SLOTS,
    parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    op_empty,
    output logic    op_pop,
    input  op_t     op_in,
    input  logic    res_full,
    output logic    res_push,
    output result_t res,
    output logic    init_busy
);

    localparam int CW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW     = CW + RW;
    localparam int DEPTH  = 1 << AW;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SI_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WORD_W = CNT_W + SLOTS * INDEX_BITS;

    localparam logic [2:0] B_INIT  = 3'd0;
    localparam logic [2:0] B_IDLE  = 3'd1;
    localparam logic [2:0] B_CLEAR = 3'd2;
    localparam logic [2:0] B_RD_S  = 3'd3;
    localparam logic [2:0] B_TAKE  = 3'd4;
    localparam logic [2:0] B_RD_E  = 3'd5;
    localparam logic [2:0] B_APP   = 3'd6;
    localparam logic [2:0] B_DONE  = 3'd7;

    logic [2:0]    state_reg, state_next;
    op_t           op_reg, op_next;
    result_t       res_reg, res_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic [AW-1:0] s_addr, e_addr;
    logic [INDEX_BITS-1:0] part_w;
    logic [CNT_W-1:0] n_raw, n;
    logic [INDEX_BITS-1:0] slots [SLOTS];
    logic [INDEX_BITS-1:0] take_slots [SLOTS];
    logic [INDEX_BITS-1:0] app_slots [SLOTS];
    logic          found;
    logic [SI_W-1:0] idx;
    logic [CNT_W-1:0] app_cnt;
    logic [2:0]    app_status;
    logic [WORD_W-1:0] take_word, app_word;

    assign init_busy = (state_reg == B_INIT);
    assign res       = res_reg;
    assign s_addr    = {op_reg.s_row[RW-1:0], op_reg.s_col[CW-1:0]};
    assign e_addr    = {op_reg.e_row[RW-1:0], op_reg.e_col[CW-1:0]};
    assign part_w    = INDEX_BITS'(op_reg.part);

    // cell store: count above the slots
    pcb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // unpack the cell read back
    always_comb
    begin
        n_raw = ram_rdata[WORD_W-1 -: CNT_W];
        n     = (n_raw > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : n_raw;
        for (int i = 0; i < SLOTS; i++)
        begin
            slots[i] = ram_rdata[i*INDEX_BITS +: INDEX_BITS];
        end
    end

    // removal: first match, later slots shift down
    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!found && (CNT_W'(i) < n) && (slots[i] == part_w))
            begin
                found = 1'b1;
                idx   = SI_W'(i);
            end
        end
        for (int j = 0; j < SLOTS; j++)
        begin
            take_slots[j] = slots[j];
        end
        for (int j = 0; j < SLOTS - 1; j++)
        begin
            if (SI_W'(j) >= idx)
            begin
                take_slots[j] = slots[j + 1];
            end
        end
        take_word[WORD_W-1 -: CNT_W] = n - 1'b1;
        for (int j = 0; j < SLOTS; j++)
        begin
            take_word[j*INDEX_BITS +: INDEX_BITS] = take_slots[j];
        end
    end

    // append: a full cell overwrites slot zero
    always_comb
    begin
        for (int j = 0; j < SLOTS; j++)
        begin
            app_slots[j] = slots[j];
        end
        if (n >= CNT_W'(SLOTS))
        begin
            app_slots[0] = part_w;
            app_cnt      = CNT_W'(SLOTS);
            app_status   = ST_OVERWRITE;
        end
        else
        begin
            app_slots[n[SI_W-1:0]] = part_w;
            app_cnt    = n + 1'b1;
            app_status = ST_PLACED;
        end
        app_word[WORD_W-1 -: CNT_W] = app_cnt;
        for (int j = 0; j < SLOTS; j++)
        begin
            app_word[j*INDEX_BITS +: INDEX_BITS] = app_slots[j];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        res_next   = res_reg;
        sweep_next = sweep_reg;
        ram_we     = 1'b0;
        ram_waddr  = sweep_reg;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = s_addr;
        op_pop     = 1'b0;
        res_push   = 1'b0;
        unique case (state_reg)
            B_INIT, B_CLEAR:
            begin
                ram_we = 1'b1;
                if (&sweep_reg)
                begin
                    sweep_next = '0;
                    state_next = (state_reg == B_INIT) ? B_IDLE : B_DONE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            B_IDLE:
            begin
                if (!op_empty && !res_full)
                begin
                    op_pop   = 1'b1;
                    op_next  = op_in;
                    res_next = '0;
                    unique case (op_in.kind)
                        OP_CLEAR:
                        begin
                            state_next = B_CLEAR;
                        end
                        OP_PLACE:
                        begin
                            if (op_in.s_in)
                            begin
                                state_next = B_RD_S;
                            end
                            else if (op_in.e_in)
                            begin
                                state_next = B_RD_E;
                            end
                            else
                            begin
                                res_next.status = ST_OUTSIDE;
                                state_next      = B_DONE;
                            end
                        end
                        OP_PEEK:
                        begin
                            res_next.status = ST_SAME;
                            state_next      = op_in.e_in ? B_RD_E : B_DONE;
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_RD_S:
            begin
                ram_re     = 1'b1;
                ram_raddr  = s_addr;
                state_next = B_TAKE;
            end
            B_TAKE:
            begin
                if (found)
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = s_addr;
                    ram_wdata        = take_word;
                    res_next.removed = 1'b1;
                end
                if (op_reg.e_in)
                begin
                    state_next = B_RD_E;
                end
                else
                begin
                    res_next.status = ST_OUTSIDE;
                    state_next      = B_DONE;
                end
            end
            B_RD_E:
            begin
                ram_re     = 1'b1;
                ram_raddr  = e_addr;
                state_next = B_APP;
            end
            B_APP:
            begin
                res_next.cell_column = 9'(op_reg.e_col);
                res_next.cell_row    = 8'(op_reg.e_row);
                if (op_reg.kind == OP_PEEK)
                begin
                    res_next.count_after = 3'(n);
                end
                else
                begin
                    ram_we               = 1'b1;
                    ram_waddr            = e_addr;
                    ram_wdata            = app_word;
                    res_next.status      = app_status;
                    res_next.count_after = 3'(app_cnt);
                end
                state_next = B_DONE;
            end
            B_DONE:
            begin
                res_push   = 1'b1;
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_INIT;
            sweep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
        end
    end

    // operation and result payload
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        res_reg <= res_next;
    end

endmodule

### hw/rtl/particle_cell_binning_unit.sv
// Uniform-grid particle binning unit.
// Input channel: push / full with cmd, particle_index and positions; a
// transaction completes on a clock edge with push high and full low.
// Result channel: empty / pop; the oldest result stays on the result ports
// while empty is low and leaves on an edge with pop high.
// Configuration: cfg_write, cfg_index, cfg_data, written while idle.
// A front end classifies each command (a 16x17 multiply for the prediction,
// then two 12-bit dividers giving 4 quotient bits per cycle); a two-entry
// queue passes the classified operation to a back end that does a
// read-modify-write of the cell store, one cell word at a time.
// The front takes the next item while the back works on the last one.
// Clear sweeps the whole cell store, one cell a cycle; the store holds
// 2^(log2 columns + log2 rows) cells, 131072 at the default size.
// After reset the same sweep runs first and full stays high until it ends.
// When the receiver stalls, two results wait in the output queue; the back end
// then takes no more operations, the operation queue fills and full stays high.
module particle_cell_binning_unit import pcb_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int SLOTS       = DEF_SLOTS,
    parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  cmd,
    input  logic [15:0] particle_index,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [15:0] vel_x,
    input  logic [15:0] vel_y,
    input  logic [15:0] end_x,
    input  logic [15:0] end_y,
    output logic        empty,
    input  logic        pop,
    output logic [8:0]  cell_column,
    output logic [7:0]  cell_row,
    output logic [2:0]  status,
    output logic        removed,
    output logic [2:0]  count_after
);

    logic [6:0]  cell_width_reg;
    logic [6:0]  cell_height_reg;
    logic [9:0]  grid_columns_reg;
    logic [8:0]  grid_rows_reg;
    logic [15:0] time_step_reg;
    cfg_t        cfg;
    logic        init_busy;
    logic        op_full, op_push, op_empty, op_pop;
    op_t         op_front, op_back;
    logic        res_full, res_push;
    result_t     res_back, res_head;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg   <= 7'd4;
            cell_height_reg  <= 7'd4;
            grid_columns_reg <= 10'd450;
            grid_rows_reg    <= 9'd250;
            time_step_reg    <= 16'd1092;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CELL_WIDTH:   cell_width_reg   <= cfg_data[6:0];
                REG_CELL_HEIGHT:  cell_height_reg  <= cfg_data[6:0];
                REG_GRID_COLUMNS: grid_columns_reg <= cfg_data[9:0];
                REG_GRID_ROWS:    grid_rows_reg    <= cfg_data[8:0];
                REG_TIME_STEP:    time_step_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // effective sizes: zero cell size acts as one, grid saturates
    always_comb
    begin
        cfg.size_x    = (cell_width_reg == 7'd0) ? 7'd1 : cell_width_reg;
        cfg.size_y    = (cell_height_reg == 7'd0) ? 7'd1 : cell_height_reg;
        cfg.dim_x     = ({3'd0, grid_columns_reg} > DIM_W'(MAX_COLUMNS)) ?
                        DIM_W'(MAX_COLUMNS) : {3'd0, grid_columns_reg};
        cfg.dim_y     = ({4'd0, grid_rows_reg} > DIM_W'(MAX_ROWS)) ?
                        DIM_W'(MAX_ROWS) : {4'd0, grid_rows_reg};
        cfg.time_step = time_step_reg;
    end

    pcb_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .hold           (init_busy),
        .push           (push),
        .full           (full),
        .cmd            (cmd),
        .particle_index (particle_index),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .vel_x          (vel_x),
        .vel_y          (vel_y),
        .end_x          (end_x),
        .end_y          (end_y),
        .op_full        (op_full),
        .op_push        (op_push),
        .op             (op_front)
    );

    // queue of classified operations
    pcb_fifo #(
        .item_t (op_t)
    ) u_op_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .full  (op_full),
        .din   (op_front),
        .pop   (op_pop),
        .empty (op_empty),
        .dout  (op_back)
    );

    pcb_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .SLOTS       (SLOTS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_empty  (op_empty),
        .op_pop    (op_pop),
        .op_in     (op_back),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_back),
        .init_busy (init_busy)
    );

    // output queue
    pcb_fifo #(
        .item_t (result_t)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .din   (res_back),
        .pop   (pop),
        .empty (empty),
        .dout  (res_head)
    );

    assign cell_column = res_head.cell_column;
    assign cell_row    = res_head.cell_row;
    assign status      = res_head.status;
    assign removed     = res_head.removed;
    assign count_after = res_head.count_after;

endmodule
